// ===== sv/ilid_pkg.sv =====
// Package with operation codes, status codes and control types for the indexed list core.
`default_nettype none
package ilid_pkg;

  localparam logic [2:0] OP_READ   = 3'd0;
  localparam logic [2:0] OP_FRONT  = 3'd1;
  localparam logic [2:0] OP_APPEND = 3'd2;
  localparam logic [2:0] OP_INSERT = 3'd3;
  localparam logic [2:0] OP_DELETE = 3'd4;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic signed [31:0] MISS_VALUE = -32'sd1;

  typedef struct packed {
    logic load;
    logic exec;
  } ilid_cmd_t;

endpackage
`default_nettype wire

// ===== sv/ilid_ctrl.sv =====
// Controller state machine that sequences request capture, execution and result delivery.
`default_nettype none
module ilid_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output ilid_pkg::ilid_cmd_t   cmd
);
  import ilid_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_HOLD;
      end
      S_HOLD: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_HOLD);
  assign cmd.load  = in_valid && (state_r == S_IDLE);
  assign cmd.exec  = (state_r == S_EXEC);

endmodule
`default_nettype wire

// ===== sv/ilid_dp.sv =====
// Datapath with the shifting cell row, element count and result registers.
`default_nettype none
module ilid_dp #(
  parameter int CAPACITY = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ilid_pkg::ilid_cmd_t cmd,
  input  wire logic [2:0]          in_mode,
  input  wire logic [4:0]          in_index,
  input  wire logic signed [31:0]  in_data_in,
  output logic signed [31:0]       out_data_out,
  output logic                     out_hit,
  output logic [1:0]               out_status,
  output logic [4:0]               out_count_after
);
  import ilid_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

  logic [2:0]         req_mode_r;
  logic [4:0]         req_index_r;
  logic signed [31:0] req_data_r;

  logic signed [31:0] cell_r   [CAPACITY];
  logic signed [31:0] cell_nxt [CAPACITY];
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;

  logic signed [31:0] data_r;
  logic               hit_r;
  logic [1:0]         status_r;
  logic [4:0]         count_after_r;

  logic [CMP_W-1:0]   cnt_ext;
  logic [CMP_W-1:0]   idx_ext;
  logic [CMP_W-1:0]   pos;
  logic               full;
  logic               do_ins;
  logic               do_del;
  logic signed [31:0] rd_data;
  logic signed [31:0] res_data;
  logic               res_hit;
  logic [1:0]         res_status;
  logic [CMP_W-1:0]   cnt_nxt_ext;

  assign cnt_ext = CMP_W'(count_r);
  assign idx_ext = CMP_W'(req_index_r);
  assign full    = (count_r == CNT_W'(CAPACITY));

  always_comb begin
    rd_data = MISS_VALUE;
    for (int k = 0; k < CAPACITY; k++) begin
      if (CMP_W'(k) == idx_ext) begin
        rd_data = cell_r[k];
      end
    end
  end

  always_comb begin
    do_ins     = 1'b0;
    do_del     = 1'b0;
    pos        = '0;
    res_status = ST_DONE;
    res_hit    = 1'b0;
    res_data   = MISS_VALUE;
    case (req_mode_r)
      OP_READ: begin
        if (idx_ext < cnt_ext) begin
          res_hit  = 1'b1;
          res_data = rd_data;
        end else begin
          res_status = ST_RANGE;
        end
      end
      OP_FRONT: begin
        if (full) begin
          res_status = ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      OP_APPEND: begin
        if (full) begin
          res_status = ST_FULL;
        end else begin
          do_ins = 1'b1;
          pos    = cnt_ext;
        end
      end
      OP_INSERT: begin
        if (idx_ext > cnt_ext) begin
          res_status = ST_RANGE;
        end else if (full) begin
          res_status = ST_FULL;
        end else begin
          do_ins = 1'b1;
          pos    = idx_ext;
        end
      end
      OP_DELETE: begin
        if (idx_ext < cnt_ext) begin
          do_del = 1'b1;
          pos    = idx_ext;
        end else begin
          res_status = ST_RANGE;
        end
      end
      default: begin
      end
    endcase
  end

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    always_comb begin
      cell_nxt[k] = cell_r[k];
      if (cmd.exec && do_ins) begin
        if (CMP_W'(k) == pos) begin
          cell_nxt[k] = req_data_r;
        end
        if (k > 0) begin
          if (CMP_W'(k) > pos) begin
            cell_nxt[k] = cell_r[(k > 0) ? k - 1 : 0];
          end
        end
      end else if (cmd.exec && do_del) begin
        if (k < CAPACITY - 1) begin
          if (CMP_W'(k) >= pos) begin
            cell_nxt[k] = cell_r[(k < CAPACITY - 1) ? k + 1 : k];
          end
        end
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.exec && do_ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.exec && do_del) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  assign cnt_nxt_ext = CMP_W'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < CAPACITY; k++) begin
      cell_r[k] <= cell_nxt[k];
    end
    if (cmd.load) begin
      req_mode_r  <= in_mode;
      req_index_r <= in_index;
      req_data_r  <= in_data_in;
    end
    if (cmd.exec) begin
      data_r        <= res_data;
      hit_r         <= res_hit;
      status_r      <= res_status;
      count_after_r <= cnt_nxt_ext[4:0];
    end
  end

  assign out_data_out    = data_r;
  assign out_hit         = hit_r;
  assign out_status      = status_r;
  assign out_count_after = count_after_r;

endmodule
`default_nettype wire

// ===== sv/indexed_list_insert_delete_core.sv =====
// Top level of the indexed list core with insert and delete at any position.
//
//   Channel | Direction | Handshake             | Payload
//   in_     | input     | in_valid / in_ready   | in_mode, in_index, in_data_in
//   out_    | output    | out_valid / out_ready | out_data_out, out_hit, out_status,
//           |           |                       | out_count_after
//
// Each request passes through capture, execution in the cell row, and delivery.
// The cell row shifts the stored elements from the given position onward in the execution
// step, so insert and delete at any position complete within that step.
// Reset clears the element count and the controller; cell contents are not cleared.
// A stalled result holds the block until it is taken, and then the next request is accepted.
`default_nettype none
module indexed_list_insert_delete_core #(
  parameter int CAPACITY = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         in_mode,
  input  wire logic [4:0]         in_index,
  input  wire logic signed [31:0] in_data_in,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_data_out,
  output logic                    out_hit,
  output logic [1:0]              out_status,
  output logic [4:0]              out_count_after
);
  import ilid_pkg::*;

  ilid_cmd_t cmd;

  ilid_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  ilid_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_mode         (in_mode),
    .in_index        (in_index),
    .in_data_in      (in_data_in),
    .out_data_out    (out_data_out),
    .out_hit         (out_hit),
    .out_status      (out_status),
    .out_count_after (out_count_after)
  );

endmodule
`default_nettype wire

// ===== dv/tb_indexed_list_insert_delete_core.sv =====
// Testbench for the indexed list core: directed and random requests checked against a predictor.
module tb_indexed_list_insert_delete_core;
  import ilid_pkg::*;

  localparam int CAPACITY = 16;
  localparam int MAX_GAP = 18;
  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_REQUESTS = 850;
  localparam int DRAIN_AT = 400;
  localparam int SETTLE_CYCLES = 10;
  localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] OP_UNUSED_LAST = 3'd7;

  typedef struct packed {
    logic signed [31:0] data;
    logic hit;
    logic [1:0] status;
    logic [4:0] count;
  } list_result_t;

  class list_scoreboard;
    logic signed [31:0] cells[CAPACITY];
    int count;
    list_result_t expected_results[$];
    int errors;

    function new();
      count = 0;
      errors = 0;
    endfunction

    function int level();
      return count;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function logic [1:0] insert_cell(int pos, logic signed [31:0] value);
      if (count >= CAPACITY) return ST_FULL;
      for (int k = count; k > pos; k--) cells[k] = cells[k - 1];
      cells[pos] = value;
      count++;
      return ST_DONE;
    endfunction

    function list_result_t apply_request(logic [2:0] mode, logic [4:0] index,
                                         logic signed [31:0] value);
      list_result_t r;
      r.data = MISS_VALUE;
      r.hit = 1'b0;
      r.status = ST_DONE;
      case (mode)
        OP_READ: begin
          if (index < count) begin
            r.data = cells[index];
            r.hit = 1'b1;
          end else begin
            r.status = ST_RANGE;
          end
        end
        OP_FRONT: r.status = insert_cell(0, value);
        OP_APPEND: r.status = insert_cell(count, value);
        OP_INSERT: begin
          if (index > count) r.status = ST_RANGE;
          else r.status = insert_cell(index, value);
        end
        OP_DELETE: begin
          if (index < count) begin
            for (int k = index; k + 1 < count; k++) cells[k] = cells[k + 1];
            count--;
          end else begin
            r.status = ST_RANGE;
          end
        end
        default: ;
      endcase
      r.count = count[4:0];
      return r;
    endfunction

    function void note_request(logic [2:0] mode, logic [4:0] index, logic signed [31:0] value);
      expected_results.push_back(apply_request(mode, index, value));
    endfunction

    function void check_result(logic signed [31:0] data, logic hit, logic [1:0] status,
                               logic [4:0] count_after);
      list_result_t exp_r;
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing expected: data %h hit %b status %0d count %0d",
                 $time, data, hit, status, count_after);
        errors++;
        return;
      end
      exp_r = expected_results.pop_front();
      if (data !== exp_r.data) begin
        $display("%0t: data_out expected %h actual %h", $time, exp_r.data, data);
        errors++;
      end
      if (hit !== exp_r.hit) begin
        $display("%0t: hit expected %b actual %b", $time, exp_r.hit, hit);
        errors++;
      end
      if (status !== exp_r.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp_r.status, status);
        errors++;
      end
      if (count_after !== exp_r.count) begin
        $display("%0t: count_after expected %0d actual %0d", $time, exp_r.count, count_after);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [2:0] in_mode;
  logic [4:0] in_index;
  logic signed [31:0] in_data_in;
  logic out_valid;
  logic out_ready;
  logic signed [31:0] out_data_out;
  logic out_hit;
  logic [1:0] out_status;
  logic [4:0] out_count_after;

  list_scoreboard sb = new();
  bit sender_quiet;
  int idle_cycles;
  logic [31:0] corner_values[4] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff};

  indexed_list_insert_delete_core #(.CAPACITY(CAPACITY)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_mode(in_mode),
    .in_index(in_index),
    .in_data_in(in_data_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data_out(out_data_out),
    .out_hit(out_hit),
    .out_status(out_status),
    .out_count_after(out_count_after)
  );

  always #1 clk = ~clk;

  task automatic send_request(input logic [2:0] mode, input logic [4:0] index,
                              input logic [31:0] value, input bit drain);
    int gap;
    gap = sender_quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0 || drain) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      if (drain) begin
        do @(posedge clk); while (sb.pending() != 0);
      end
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_index <= index;
    in_data_in <= value;
    do @(posedge clk); while (!in_ready);
    sb.note_request(mode, index, value);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_data_out, out_hit, out_status, out_count_after);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    idle_cycles = 0;
    wait (idle_cycles >= IDLE_LIMIT);
    $display("%0t: no request or result moved for %0d cycles", $time, IDLE_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int stall;
    int taken;
    bit quiet;
    taken = 0;
    quiet = 1'b0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (taken % 40 == 0) quiet = ($urandom_range(0, 2) == 0);
      stall = quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      taken++;
    end
  end

  initial begin
    logic [2:0] mode;
    logic [4:0] index;
    logic [31:0] value;
    int roll;
    bit growing;
    bit pick_insert;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_mode <= OP_READ;
    in_index <= '0;
    in_data_in <= '0;
    sender_quiet = 1'b1;
    growing = 1'b1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(OP_READ, 5'd0, 32'h0, 1'b0);
    send_request(OP_DELETE, 5'd0, 32'h0, 1'b0);
    send_request(OP_INSERT, 5'd1, 32'h1111_1111, 1'b0);
    send_request(OP_INSERT, 5'd0, 32'h7fff_ffff, 1'b0);
    send_request(OP_FRONT, 5'd31, 32'h8000_0000, 1'b0);
    send_request(OP_APPEND, 5'd0, 32'hffff_ffff, 1'b0);
    send_request(OP_APPEND, 5'd0, 32'h0000_0000, 1'b0);
    send_request(OP_INSERT, 5'd2, 32'h1234_5678, 1'b0);
    send_request(OP_READ, 5'd0, 32'h0, 1'b0);
    send_request(OP_READ, 5'd4, 32'h0, 1'b0);
    send_request(OP_READ, 5'd31, 32'hffff_ffff, 1'b0);
    while (sb.level() < CAPACITY) send_request(OP_APPEND, 5'd0, $urandom, 1'b0);
    send_request(OP_FRONT, 5'd0, 32'h5555_5555, 1'b0);
    send_request(OP_APPEND, 5'd0, 32'haaaa_aaaa, 1'b0);
    send_request(OP_INSERT, 5'd3, 32'h0f0f_0f0f, 1'b0);
    send_request(OP_INSERT, 5'd17, 32'hf0f0_f0f0, 1'b0);
    send_request(OP_DELETE, 5'd15, 32'h0, 1'b0);
    send_request(OP_DELETE, 5'd0, 32'h0, 1'b0);
    send_request(OP_DELETE, 5'd7, 32'h0, 1'b0);
    send_request(OP_UNUSED_FIRST, 5'd31, 32'hffff_ffff, 1'b0);
    send_request(OP_UNUSED_LAST, 5'd0, 32'h0, 1'b0);

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 60 == 0) growing = ($urandom_range(0, 1) == 1);
      if (n % 45 == 0) sender_quiet = ($urandom_range(0, 2) == 0);
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        mode = 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
      end else if (roll < 20) begin
        mode = OP_READ;
      end else begin
        pick_insert = growing ? (roll < 80) : (roll < 45);
        if (!pick_insert) mode = OP_DELETE;
        else case ($urandom_range(0, 3))
          0: mode = OP_FRONT;
          1: mode = OP_APPEND;
          default: mode = OP_INSERT;
        endcase
      end
      if ($urandom_range(0, 4) == 0) index = 5'($urandom_range(0, 31));
      else index = 5'($urandom_range(0, sb.level() + 1));
      if ($urandom_range(0, 9) == 0) value = corner_values[$urandom_range(0, 3)];
      else value = $urandom;
      send_request(mode, index, value, n == DRAIN_AT);
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/ilid_pkg.sv
sv/ilid_ctrl.sv
sv/ilid_dp.sv
sv/indexed_list_insert_delete_core.sv
dv/tb_indexed_list_insert_delete_core.sv
